FILE: rtl/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Used by lpht_mod, lpht_mem and linear_probe_hash_table; no dependencies.
package lpht_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W     = 31;
    localparam int ACT_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int OUTCOME_W = 2;
    localparam int MARK_W    = 2;

    // Default table depth.
    localparam int SLOTS_DEF = 64;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    // Slot marks.
    localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED  = 2'd2;

    // Result outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_DONE      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NOT_FOUND = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    // Memory control from the sequencer to the slot store.
    typedef struct packed {
        logic              rd_en;
        logic              key_we;
        logic              mark_we;
        logic [MARK_W-1:0] wr_mark;
    } t_mem_ctl;

endpackage

FILE: rtl/lpht_mod.sv
// Home-slot unit: computes key mod SLOTS by reciprocal multiplication.
// Depends on lpht_pkg.
module lpht_mod #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [IW-1:0]              o_rem
);
    import lpht_pkg::*;

    // The quotient (key * RECIP) >> SHIFT is exact for every key of KEY_W bits,
    // since RECIP rounds 2^SHIFT / SLOTS up and SHIFT covers the divisor bits.
    localparam int            SHIFT    = KEY_W + IW;
    localparam logic [31:0]   RECIP    =
        32'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [IW-1:0] SLOTS_LO = IW'(SLOTS);

    logic                r_key_vld;
    logic                r_prod_vld;
    logic                r_done;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W+31:0]   r_prod;
    logic [IW-1:0]       r_rem;
    logic [IW-1:0]       quot_lo;
    logic [2*IW-1:0]     back_prod;

    // Only the low quotient bits matter: the remainder fits in IW bits.
    assign quot_lo   = r_prod[SHIFT +: IW];
    assign back_prod = quot_lo * SLOTS_LO;

    // Stage valids are reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_key_vld  <= i_start;
            r_prod_vld <= r_key_vld;
            r_done     <= r_prod_vld;
        end
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_key_vld) begin
            r_prod <= {32'd0, r_key} * {31'd0, RECIP};
        end
        if (r_prod_vld) begin
            r_rem <= r_key[IW-1:0] - back_prod[IW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/lpht_mem.sv
// Slot store: key memory and mark memory, one write and one registered read.
// Depends on lpht_pkg.
module lpht_mem #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                        i_clk,
    input  lpht_pkg::t_mem_ctl          i_ctl,
    input  logic [IW-1:0]               i_rd_addr,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic [lpht_pkg::KEY_W-1:0]  i_wr_key,
    output logic [lpht_pkg::KEY_W-1:0]  o_rd_key,
    output logic [lpht_pkg::MARK_W-1:0] o_rd_mark
);
    import lpht_pkg::*;

    logic [KEY_W-1:0]  r_keys  [SLOTS];
    logic [MARK_W-1:0] r_marks [SLOTS];
    logic [KEY_W-1:0]  r_key_q;
    logic [MARK_W-1:0] r_mark_q;

    // Key memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        if (i_ctl.rd_en) begin
            r_key_q <= r_keys[i_rd_addr];
        end
    end

    // Mark memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mark_we) begin
            r_marks[i_wr_addr] <= i_ctl.wr_mark;
        end
        if (i_ctl.rd_en) begin
            r_mark_q <= r_marks[i_rd_addr];
        end
    end

    assign o_rd_key  = r_key_q;
    assign o_rd_mark = r_mark_q;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, top level.
// Depends on lpht_pkg, lpht_mod and lpht_mem.
//
// Usage:
// The slave channel takes one command word: tuser carries the action
// (insert, lookup, remove), tdata carries the key. Action code 3 is dropped
// without a result. Every other command yields one result word on the master
// channel: tdata carries found and the slot index, tuser the outcome.
// Each command first has its home slot computed in lpht_mod (key register,
// reciprocal multiply and remainder), then probes slots in order (one read
// per cycle from the mark and key memories), then registers the result.
// Commands are handled one at a time; the next one is taken the cycle after
// the result is registered. After reset the mark memory is swept to empty,
// one slot per cycle; no command is taken during the sweep. The result sits
// in an output register; while the receiver stalls, the next command is
// still accepted and processed, and it waits for the output register to
// free.
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] key, [31] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    // Result channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] found, [6:1] slot, [7] zero
    output logic [1:0]  o_m_tuser    // [1:0] outcome
);
    import lpht_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IX = IW'(SLOTS - 1);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_ix, n_ix;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_key;
    logic [ACT_W-1:0]  r_act;
    logic              r_found, n_found;
    logic [OUTCOME_W-1:0] r_outcome, n_outcome;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic [1:0]        r_out_user;

    t_mem_ctl          mem_ctl;
    logic [IW-1:0]     rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [MARK_W-1:0] rd_mark;
    logic              mod_start, mod_done;
    logic [IW-1:0]     mod_rem;
    logic              s_accept, finish, out_load;
    logic [IW-1:0]     ix_inc;
    logic [IW+SLOT_W-1:0] slot_wide;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign ix_inc    = (r_ix == LAST_IX) ? '0 : r_ix + 1'b1;
    assign mod_start = s_accept && (i_s_tuser != ACT_NONE);

    lpht_mod #(.SLOTS(SLOTS), .IW(IW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_s_tdata[KEY_W-1:0]),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lpht_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr ((r_state == S_CLEAR) ? r_cnt : r_ix),
        .i_wr_key  (r_key),
        .o_rd_key  (rd_key),
        .o_rd_mark (rd_mark)
    );

    // Probe decisions, memory control and handshake outputs.
    always_comb begin
        mem_ctl   = '{rd_en: 1'b0, key_we: 1'b0, mark_we: 1'b0, wr_mark: MARK_EMPTY};
        rd_addr   = ix_inc;
        finish    = 1'b0;
        n_found   = r_found;
        n_outcome = r_outcome;
        n_ix      = r_ix;
        n_cnt     = r_cnt;
        out_load  = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_ctl.mark_we = 1'b1;
                mem_ctl.wr_mark = MARK_EMPTY;
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_HASH: begin
                rd_addr = mod_rem;
                if (mod_done) begin
                    mem_ctl.rd_en = 1'b1;
                    n_ix  = mod_rem;
                    n_cnt = '0;
                end
            end
            S_PROBE: begin
                if (r_act == ACT_INSERT) begin
                    if (rd_mark != MARK_OCCUPIED) begin
                        finish          = 1'b1;
                        n_found         = 1'b1;
                        n_outcome       = OUT_DONE;
                        mem_ctl.key_we  = 1'b1;
                        mem_ctl.mark_we = 1'b1;
                        mem_ctl.wr_mark = MARK_OCCUPIED;
                    end else if (r_cnt == LAST_IX) begin
                        finish    = 1'b1;
                        n_found   = 1'b0;
                        n_outcome = OUT_FULL;
                    end
                end else begin
                    if (rd_mark == MARK_OCCUPIED && rd_key == r_key) begin
                        finish    = 1'b1;
                        n_found   = 1'b1;
                        n_outcome = OUT_DONE;
                        if (r_act == ACT_REMOVE) begin
                            mem_ctl.mark_we = 1'b1;
                            mem_ctl.wr_mark = MARK_DELETED;
                        end
                    end else if (rd_mark == MARK_EMPTY || r_cnt == LAST_IX) begin
                        finish    = 1'b1;
                        n_found   = 1'b0;
                        n_outcome = OUT_NOT_FOUND;
                    end
                end
                // No decision yet: read the next slot in probe order.
                if (!finish) begin
                    mem_ctl.rd_en = 1'b1;
                    n_ix  = ix_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                out_load = !r_out_valid || i_m_tready;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == LAST_IX) n_state = S_IDLE;
            S_IDLE:  if (mod_start) n_state = S_HASH;
            S_HASH:  if (mod_done) n_state = S_PROBE;
            S_PROBE: if (finish) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Slot field: low bits of the index, zero when nothing was found.
    assign slot_wide = {{SLOT_W{1'b0}}, r_ix};

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_ix      <= n_ix;
        r_found   <= n_found;
        r_outcome <= n_outcome;
        if (s_accept) begin
            r_key <= i_s_tdata[KEY_W-1:0];
            r_act <= i_s_tuser;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= {1'b0, r_found ? slot_wide[SLOT_W-1:0] : {SLOT_W{1'b0}}, r_found};
            r_out_user <= r_outcome;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // Memory writes happen only during the sweep or on a probe decision.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.mark_we |-> (r_state == S_CLEAR || (r_state == S_PROBE && finish)))
        else $error("mark write outside sweep or probe decision");

    // A key is only stored together with an occupied mark.
    a_key_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.key_we |-> (mem_ctl.mark_we && mem_ctl.wr_mark == MARK_OCCUPIED))
        else $error("key written without occupied mark");

    // A found result always reports outcome done.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tuser == OUT_DONE))
        else $error("found result with a failure outcome");

    // A valid command moves the sequencer into the remainder phase.
    a_start_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |=> (r_state == S_HASH))
        else $error("accepted command did not start hashing");

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwrote a pending word");

endmodule
